FILE: rtl/pointer_register_machine_exec_top_defines.svh
// Assertion macros shared by the checker of the pointer register machine.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef POINTER_REGISTER_MACHINE_EXEC_TOP_DEFINES_SVH
`define POINTER_REGISTER_MACHINE_EXEC_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/prm_pkg.sv
// Shared constants for the pointer register machine: sizes, opcodes,
// result kinds and error codes. No dependencies.
`timescale 1ns / 1ps

package prm_pkg;

	localparam int MEM_DEPTH  = 16384;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int MAX_STRING = 64;
	localparam int CNT_W      = $clog2(MAX_STRING + 1);
	localparam int PC_W       = 14;
	localparam int PC_LINES   = 16384;

	localparam logic [4:0] OP_PTRX = 5'd0;
	localparam logic [4:0] OP_PTRY = 5'd1;
	localparam logic [4:0] OP_PTRZ = 5'd2;
	localparam logic [4:0] OP_PUTX = 5'd3;
	localparam logic [4:0] OP_PUTY = 5'd4;
	localparam logic [4:0] OP_PUTZ = 5'd5;
	localparam logic [4:0] OP_GOTO = 5'd6;
	localparam logic [4:0] OP_IFEQ = 5'd7;
	localparam logic [4:0] OP_IFGT = 5'd8;
	localparam logic [4:0] OP_IFLT = 5'd9;
	localparam logic [4:0] OP_ADD  = 5'd10;
	localparam logic [4:0] OP_SUB  = 5'd11;
	localparam logic [4:0] OP_MUL  = 5'd12;
	localparam logic [4:0] OP_DIV  = 5'd13;
	localparam logic [4:0] OP_POW  = 5'd14;
	localparam logic [4:0] OP_MOD  = 5'd15;
	localparam logic [4:0] OP_IFLE = 5'd16;
	localparam logic [4:0] OP_IFGE = 5'd17;
	localparam logic [4:0] OP_PRT  = 5'd18;
	localparam logic [4:0] OP_MOVX = 5'd20;
	localparam logic [4:0] OP_MOVY = 5'd21;
	localparam logic [4:0] OP_MOVZ = 5'd22;
	localparam logic [4:0] OP_SWAP = 5'd23;
	localparam logic [4:0] OP_PRTC = 5'd24;
	localparam logic [4:0] OP_PRTS = 5'd25;
	localparam logic [4:0] OP_INPC = 5'd26;
	localparam logic [4:0] OP_END  = 5'd28;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NUM  = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;
	localparam logic [1:0] KIND_END  = 2'd3;

	localparam logic [2:0] ERR_OK   = 3'd0;
	localparam logic [2:0] ERR_DIV0 = 3'd1;
	localparam logic [2:0] ERR_ADDR = 3'd2;
	localparam logic [2:0] ERR_TGT  = 3'd3;
	localparam logic [2:0] ERR_LONG = 3'd4;

endpackage

FILE: rtl/pointer_register_machine_exec_top.sv
// Flow: plain instructions read the x, y and z words in turn, execute and give
// one result word; div and mod run an iterative divider, pow a multiply loop.
// Throughput: one instruction at a time, the next is taken once the last
// result word leaves.
// Reset: asynchronous; afterwards a clearing pass zeroes memory.
`timescale 1ns / 1ps

module pointer_register_machine_exec_top
	import prm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [4:0]          opcode,
	input  logic [30:0]         arg,
	input  logic signed [8:0]   in_char,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          out_kind,
	output logic signed [31:0]  out_value,
	output logic [PC_W-1:0]     next_pc,
	output logic [2:0]          error,
	output logic                halted,
	output logic                last
);

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_RX   = 5'd2;
	localparam logic [4:0] S_RY   = 5'd3;
	localparam logic [4:0] S_RZ   = 5'd4;
	localparam logic [4:0] S_EX   = 5'd5;
	localparam logic [4:0] S_DIV  = 5'd6;
	localparam logic [4:0] S_DIVF = 5'd7;
	localparam logic [4:0] S_PMR  = 5'd8;
	localparam logic [4:0] S_PMM  = 5'd9;
	localparam logic [4:0] S_PSM  = 5'd10;
	localparam logic [4:0] S_PF   = 5'd11;
	localparam logic [4:0] S_SWAP = 5'd12;
	localparam logic [4:0] S_OUT  = 5'd13;
	localparam logic [4:0] S_SRD  = 5'd14;
	localparam logic [4:0] S_SCK  = 5'd15;
	localparam logic [4:0] S_SOUT = 5'd16;

	logic [31:0] mem_q [MEM_DEPTH];
	logic [31:0] rd_q;

	logic [4:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [4:0]        op_q;
	logic [30:0]       arg_q;
	logic [8:0]        ch_q;
	logic [ADDR_W-1:0] px_q, py_q, pz_q;
	logic [PC_W-1:0]   pc_q;
	logic              halt_q;
	logic [31:0]       vx_q, vy_q;

	logic [31:0] rem_q, quo_q, dd_q;
	logic [4:0]  dcnt_q;
	logic        qneg_q, rneg_q;

	logic [31:0] r_q, m_q;
	logic [30:0] n_q;
	logic        pneg_q;
	logic [63:0] prod_q;

	logic [30:0]      sa_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_q;
	logic [7:0]       pch_q;

	logic              out_valid_q, out_last_q, out_halt_q;
	logic [1:0]        out_kind_q;
	logic [31:0]       out_value_q;
	logic [PC_W-1:0]   out_pc_q;
	logic [2:0]        out_err_q;

	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [31:0]       wr_data;

	logic              addr_ok, sa_ok, tgt_ok, taken;
	logic [ADDR_W-1:0] arg_lo;
	logic [31:0]       vz, mul_lo, sext_ch, pow_neg, sat_p, div_res, pow_res;
	logic [32:0]       div_sh;
	logic              ex_wr;
	logic [ADDR_W-1:0] ex_waddr;
	logic [31:0]       ex_wdata;
	logic [2:0]        ex_err;
	logic [1:0]        ex_kind;
	logic [31:0]       ex_val;
	logic [PC_W-1:0]   ex_pc;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_value = out_value_q;
	assign next_pc   = out_pc_q;
	assign error     = out_err_q;
	assign halted    = out_halt_q;
	assign last      = out_last_q;

	assign arg_lo  = arg_q[ADDR_W-1:0];
	assign addr_ok = ({1'b0, arg_q} < 32'(MEM_DEPTH));
	assign sa_ok   = ({1'b0, sa_q} < 32'(MEM_DEPTH));
	assign tgt_ok  = (arg_q != 31'd0) && ({1'b0, arg_q} <= 32'(PC_LINES));
	assign vz      = rd_q;
	assign mul_lo  = 32'(vx_q * vy_q);
	assign sext_ch = {{23{ch_q[8]}}, ch_q};
	assign div_sh  = {rem_q, quo_q[31]};
	assign sat_p   = (prod_q > 64'h8000_0000) ? 32'h8000_0001 : prod_q[31:0];

	// A negative exponent only leaves 1, -1 or 0 depending on the base.
	always_comb begin
		if (vx_q == 32'd1) begin
			pow_neg = 32'd1;
		end else if (vx_q == 32'hFFFF_FFFF) begin
			pow_neg = vy_q[0] ? 32'hFFFF_FFFF : 32'd1;
		end else begin
			pow_neg = 32'd0;
		end
	end

	always_comb begin
		if (op_q == OP_DIV) begin
			div_res = qneg_q ? (32'd0 - quo_q) : quo_q;
		end else begin
			div_res = rneg_q ? (32'd0 - rem_q) : rem_q;
		end
		if (pneg_q) begin
			pow_res = (r_q >= 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - r_q);
		end else begin
			pow_res = (r_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_q;
		end
	end

	always_comb begin
		case (op_q)
			OP_GOTO: taken = 1'b1;
			OP_IFEQ: taken = (vx_q == vy_q);
			OP_IFGT: taken = ($signed(vx_q) > $signed(vy_q));
			OP_IFLT: taken = ($signed(vx_q) < $signed(vy_q));
			OP_IFLE: taken = ($signed(vx_q) <= $signed(vy_q));
			OP_IFGE: taken = ($signed(vx_q) >= $signed(vy_q));
			default: taken = 1'b0;
		endcase
	end

	// Single-result execution: memory write, error, printed word, next program counter.
	always_comb begin
		ex_wr    = 1'b0;
		ex_waddr = pz_q;
		ex_wdata = 32'd0;
		ex_err   = ERR_OK;
		ex_kind  = KIND_NONE;
		ex_val   = 32'd0;
		case (op_q)
			OP_PTRX, OP_PTRY, OP_PTRZ: begin
				if (!addr_ok) ex_err = ERR_ADDR;
			end
			OP_PUTX: begin
				ex_wr = 1'b1; ex_waddr = px_q; ex_wdata = {1'b0, arg_q};
			end
			OP_PUTY: begin
				ex_wr = 1'b1; ex_waddr = py_q; ex_wdata = {1'b0, arg_q};
			end
			OP_PUTZ: begin
				ex_wr = 1'b1; ex_wdata = {1'b0, arg_q};
			end
			OP_ADD: begin
				ex_wr = 1'b1; ex_wdata = vx_q + vy_q;
			end
			OP_SUB: begin
				ex_wr = 1'b1; ex_wdata = vx_q - vy_q;
			end
			OP_MUL: begin
				ex_wr = 1'b1; ex_wdata = mul_lo;
			end
			OP_DIV, OP_MOD: begin
				if (vy_q == 32'd0) ex_err = ERR_DIV0;
			end
			OP_POW: begin
				if (vy_q[31]) begin
					if (vx_q == 32'd0) begin
						ex_err = ERR_DIV0;
					end else begin
						ex_wr = 1'b1; ex_wdata = pow_neg;
					end
				end
			end
			OP_PRT: begin
				if (addr_ok) begin
					ex_kind = KIND_NUM; ex_val = vz;
				end else begin
					ex_err = ERR_ADDR;
				end
			end
			OP_PRTC: begin
				if (addr_ok) begin
					ex_kind = KIND_CHAR; ex_val = {24'd0, vz[7:0]};
				end else begin
					ex_err = ERR_ADDR;
				end
			end
			OP_MOVX, OP_MOVY, OP_MOVZ, OP_INPC: begin
				if (addr_ok) begin
					ex_wr    = 1'b1;
					ex_waddr = arg_lo;
					case (op_q)
						OP_MOVX: ex_wdata = vx_q;
						OP_MOVY: ex_wdata = vy_q;
						OP_MOVZ: ex_wdata = vz;
						default: ex_wdata = sext_ch;
					endcase
				end else begin
					ex_err = ERR_ADDR;
				end
			end
			OP_SWAP: begin
				ex_wr = 1'b1; ex_waddr = px_q; ex_wdata = vy_q;
			end
			default: begin
				ex_wr = 1'b0;
			end
		endcase
		if (taken && !tgt_ok) ex_err = ERR_TGT;
		if (taken && tgt_ok) begin
			ex_pc = arg_q[PC_W-1:0] - PC_W'(1);
		end else begin
			ex_pc = pc_q + PC_W'(1);
		end
	end

	// Memory port control per state.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pz_q;
		wr_data = 32'd0;
		rd_en   = 1'b0;
		rd_addr = px_q;
		case (state_q)
			S_CLR: begin
				wr_en = 1'b1; wr_addr = clr_q;
			end
			S_RX: rd_en = 1'b1;
			S_RY: begin
				rd_en = 1'b1; rd_addr = py_q;
			end
			S_RZ: begin
				rd_en   = 1'b1;
				rd_addr = (op_q == OP_PRT || op_q == OP_PRTC) ? arg_lo : pz_q;
			end
			S_EX: begin
				wr_en = ex_wr; wr_addr = ex_waddr; wr_data = ex_wdata;
			end
			S_SWAP: begin
				wr_en = 1'b1; wr_addr = py_q; wr_data = vx_q;
			end
			S_DIVF: begin
				wr_en = 1'b1; wr_data = div_res;
			end
			S_PF: begin
				wr_en = 1'b1; wr_data = pow_res;
			end
			S_SRD: begin
				rd_en = sa_ok; rd_addr = sa_q[ADDR_W-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MEM_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q  <= opcode;
						arg_q <= arg;
						ch_q  <= in_char;
						if (halt_q) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= KIND_NONE;
							out_value_q <= 32'd0;
							out_pc_q    <= pc_q;
							out_err_q   <= ERR_OK;
							out_halt_q  <= 1'b1;
							out_last_q  <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							state_q <= S_RX;
						end
					end
				end
				S_RX: state_q <= S_RY;
				S_RY: begin
					vx_q    <= rd_q;
					state_q <= S_RZ;
				end
				S_RZ: begin
					vy_q    <= rd_q;
					state_q <= S_EX;
				end
				S_EX: begin
					// Defaults give the one-word result; long operations override.
					out_kind_q  <= ex_kind;
					out_value_q <= ex_val;
					out_err_q   <= ex_err;
					out_halt_q  <= 1'b0;
					out_last_q  <= 1'b1;
					out_pc_q    <= ex_pc;
					out_valid_q <= 1'b1;
					pc_q        <= ex_pc;
					state_q     <= S_OUT;
					if (addr_ok && op_q == OP_PTRX) px_q <= arg_lo;
					if (addr_ok && op_q == OP_PTRY) py_q <= arg_lo;
					if (addr_ok && op_q == OP_PTRZ) pz_q <= arg_lo;
					if ((op_q == OP_DIV || op_q == OP_MOD) && vy_q != 32'd0) begin
						out_valid_q <= 1'b0;
						rem_q       <= 32'd0;
						quo_q       <= vx_q[31] ? (32'd0 - vx_q) : vx_q;
						dd_q        <= vy_q[31] ? (32'd0 - vy_q) : vy_q;
						qneg_q      <= vx_q[31] ^ vy_q[31];
						rneg_q      <= vx_q[31];
						dcnt_q      <= '0;
						state_q     <= S_DIV;
					end
					if (op_q == OP_POW && !vy_q[31]) begin
						out_valid_q <= 1'b0;
						r_q         <= 32'd1;
						m_q         <= vx_q[31] ? (32'd0 - vx_q) : vx_q;
						n_q         <= vy_q[30:0];
						pneg_q      <= vx_q[31] & vy_q[0];
						state_q     <= (vy_q[30:0] == 31'd0) ? S_PF : S_PMR;
					end
					if (op_q == OP_SWAP) begin
						out_valid_q <= 1'b0;
						state_q     <= S_SWAP;
					end
					if (op_q == OP_PRTS) begin
						out_valid_q <= 1'b0;
						sa_q        <= arg_q;
						cnt_q       <= '0;
						pend_q      <= 1'b0;
						state_q     <= S_SRD;
					end
					if (op_q == OP_END) begin
						halt_q      <= 1'b1;
						out_kind_q  <= KIND_END;
						out_value_q <= 32'd0;
						out_err_q   <= ERR_OK;
						out_halt_q  <= 1'b1;
						out_pc_q    <= pc_q;
						pc_q        <= pc_q;
					end
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle.
					if (div_sh >= {1'b0, dd_q}) begin
						rem_q <= 32'(div_sh - {1'b0, dd_q});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= div_sh[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) state_q <= S_DIVF;
				end
				S_PMR: begin
					prod_q  <= 64'(r_q) * 64'(m_q);
					state_q <= S_PMM;
				end
				S_PMM: begin
					if (n_q[0]) r_q <= sat_p;
					prod_q  <= 64'(m_q) * 64'(m_q);
					state_q <= S_PSM;
				end
				S_PSM: begin
					n_q <= n_q >> 1;
					if (n_q[30:1] != 30'd0) begin
						m_q     <= sat_p;
						state_q <= S_PMR;
					end else begin
						state_q <= S_PF;
					end
				end
				S_DIVF, S_PF, S_SWAP: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_SRD: begin
					if (sa_ok) begin
						state_q <= S_SCK;
					end else begin
						out_kind_q  <= pend_q ? KIND_CHAR : KIND_NONE;
						out_value_q <= pend_q ? {24'd0, pch_q} : 32'd0;
						out_err_q   <= ERR_ADDR;
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_SCK: begin
					// A character word is held back until the next word shows
					// whether it is the last one of the string.
					if (rd_q == 32'd0 || cnt_q == CNT_W'(MAX_STRING)) begin
						out_kind_q  <= pend_q ? KIND_CHAR : KIND_NONE;
						out_value_q <= pend_q ? {24'd0, pch_q} : 32'd0;
						out_err_q   <= (rd_q == 32'd0) ? ERR_OK : ERR_LONG;
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						pend_q <= 1'b1;
						pch_q  <= rd_q[7:0];
						cnt_q  <= cnt_q + CNT_W'(1);
						sa_q   <= sa_q + 31'd1;
						if (pend_q) begin
							out_kind_q  <= KIND_CHAR;
							out_value_q <= {24'd0, pch_q};
							out_err_q   <= ERR_OK;
							out_last_q  <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= S_SOUT;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SOUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= S_SRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/prm_checker.sv
// Port-level checker for the pointer register machine, bound to the top level.
// Depends on prm_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "pointer_register_machine_exec_top_defines.svh"

module prm_checker
	import prm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         out_kind,
	input logic signed [31:0] out_value,
	input logic [2:0]         error,
	input logic               halted,
	input logic               last
);

	// A stalled result word must keep its value.
	`PRM_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_value), "result word changed while stalled")
	// Once a word is accepted the block is busy with it.
	`PRM_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "input accepted twice in a row")
	// Only string characters may be followed by more words of the same instruction.
	`PRM_ASSERT_NOW(a_multi, out_valid && !last, out_kind == KIND_CHAR && error == ERR_OK, "non-final word is not a plain character")
	// The end instruction reports a halted machine in a single word.
	`PRM_ASSERT_NOW(a_end, out_valid && out_kind == KIND_END, last && halted && out_value == 0, "end word malformed")

endmodule

bind pointer_register_machine_exec_top prm_checker u_prm_checker (.*);
